[sv/calendar_date_decrement_defines.svh]
// Assertion macros shared by the calendar date decrement checker.
// No dependencies.
`ifndef CALENDAR_DATE_DECREMENT_DEFINES_SVH
`define CALENDAR_DATE_DECREMENT_DEFINES_SVH

// expr must never hold outside reset
`define CDD_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("cdd assertion failed");

// cons must hold in the same cycle as ante
`define CDD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cdd assertion failed");

// cons must hold in the cycle after ante
`define CDD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cdd assertion failed");

`endif

[sv/cdd_pkg.sv]
// Shared types, constants and calendar functions for the date decrementer.
// No dependencies.
package cdd_pkg;

    typedef enum logic [2:0] {
        OP_DAY        = 3'd0,
        OP_WEEK       = 3'd1,
        OP_MONTH      = 3'd2,
        OP_YEAR       = 3'd3,
        OP_DECADE     = 3'd4,
        OP_CENTURY    = 3'd5,
        OP_MILLENNIUM = 3'd6
    } t_op;

    typedef struct packed {
        logic done;
        logic uf;
    } t_step_sts;

    localparam logic [4:0]  DIV25        = 5'd25;
    localparam logic [4:0]  R25_TOP      = 5'd24;
    localparam logic [16:0] RECIP25      = 17'd83887;  // ceil(2^21 / 25), exact below 91180
    localparam int          RECIP_SHIFT  = 21;
    localparam logic [3:0]  MONTH_JAN    = 4'd1;
    localparam logic [3:0]  MONTH_DEC    = 4'd12;
    localparam logic [4:0]  DAY_FIRST    = 5'd1;
    localparam logic [4:0]  DAY_DEC_LAST = 5'd31;

    // year % 4 == 0 and not % 100, or % 400; r25 is year % 25
    function automatic logic is_leap(input logic [3:0] y_lo, input logic [4:0] r25);
        logic leap;
        leap = ((y_lo[1:0] == 2'd0) && (r25 != 5'd0)) ||
               ((y_lo == 4'd0) && (r25 == 5'd0));
        return leap;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        if (m == 4'd2) begin
            len = leap ? 5'd29 : 5'd28;
        end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
            len = 5'd30;
        end else begin
            len = 5'd31;
        end
        return len;
    endfunction

    function automatic logic [15:0] unit_of(input t_op op);
        logic [15:0] u;
        case (op)
            OP_YEAR:       u = 16'd1;
            OP_DECADE:     u = 16'd10;
            OP_CENTURY:    u = 16'd100;
            OP_MILLENNIUM: u = 16'd1000;
            default:       u = 16'd0;
        endcase
        return u;
    endfunction

endpackage

[sv/cdd_if.sv]
// Request and response channel interfaces of the date decrementer.
// Widths follow COUNT_BITS and YEAR_BITS; no package dependency.
interface cdd_req_if #(
    parameter int COUNT_BITS = 10,
    parameter int YEAR_BITS  = 14
);
    logic                  valid;
    logic                  ready;
    logic [2:0]            operation;
    logic [COUNT_BITS-1:0] step_count;
    logic [4:0]            day_in;
    logic [3:0]            month_in;
    logic [YEAR_BITS-1:0]  year_in;

    modport source (output valid, operation, step_count, day_in, month_in, year_in,
                    input ready);
    modport sink   (input valid, operation, step_count, day_in, month_in, year_in,
                    output ready);
endinterface

interface cdd_rsp_if #(
    parameter int YEAR_BITS = 14
);
    logic                 valid;
    logic                 ready;
    logic [4:0]           day_out;
    logic [3:0]           month_out;
    logic [YEAR_BITS-1:0] year_out;
    logic                 year_underflow;

    modport source (output valid, day_out, month_out, year_out, year_underflow,
                    input ready);
    modport sink   (input valid, day_out, month_out, year_out, year_underflow,
                    output ready);
endinterface

[sv/calendar_date_decrement.sv]
// Year, decade, century, millennium and unused codes go through S_PREP and S_FIX to
// S_DONE; day, week and month steps add S_WALK, which crosses one month boundary
// per pass (month steps: one month per pass, ending early on underflow). The walk is
// one pass of the shared step unit per cycle. One request at a time: not ready until
// the result is transferred, and ready again the cycle after that transfer.
// Synchronous active-low reset returns the sequencer to idle.
module calendar_date_decrement
    import cdd_pkg::*;
#(
    parameter int COUNT_BITS = 10,
    parameter int YEAR_BITS  = 14
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cdd_req_if.sink   i_req,
    cdd_rsp_if.source o_rsp
);

    localparam int REM_BITS = COUNT_BITS + 3;
    localparam int MUL_A    = (YEAR_BITS > COUNT_BITS) ? YEAR_BITS : COUNT_BITS;
    localparam int PW       = MUL_A + 17;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_FIX  = 5'b00100,
        S_WALK = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    t_op                  r_op;
    logic [4:0]           r_day;
    logic [3:0]           r_month;
    logic [YEAR_BITS-1:0] r_year;
    logic [4:0]           r_r25;
    logic [REM_BITS-1:0]  r_rem;
    logic [PW-1:0]        r_prod;
    logic                 r_uf;

    logic                 year_op;
    logic [MUL_A-1:0]     mul_a;
    logic [16:0]          mul_b;
    logic [PW-1:0]        fix_r;
    logic [4:0]           s_day;
    logic [3:0]           s_month;
    logic [YEAR_BITS-1:0] s_year;
    logic [4:0]           s_r25;
    logic [REM_BITS-1:0]  s_rem;
    t_step_sts            s_sts;

    assign year_op = (r_op == OP_YEAR) || (r_op == OP_DECADE) ||
                     (r_op == OP_CENTURY) || (r_op == OP_MILLENNIUM);
    assign mul_a   = year_op ? MUL_A'(r_rem) : MUL_A'(r_year);
    assign mul_b   = year_op ? 17'(unit_of(r_op)) : RECIP25;
    assign fix_r   = PW'(r_year) - (r_prod >> RECIP_SHIFT) * PW'(DIV25);

    cdd_step #(
        .YEAR_BITS (YEAR_BITS),
        .REM_BITS  (REM_BITS)
    ) u_step (
        .i_month_mode (r_op == OP_MONTH),
        .i_day        (r_day),
        .i_month      (r_month),
        .i_year       (r_year),
        .i_r25        (r_r25),
        .i_rem        (r_rem),
        .o_day        (s_day),
        .o_month      (s_month),
        .o_year       (s_year),
        .o_r25        (s_r25),
        .o_rem        (s_rem),
        .o_sts        (s_sts)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_req.valid) n_state = S_PREP;
            S_PREP: n_state = S_FIX;
            S_FIX: begin
                if (year_op || (r_op != OP_DAY && r_op != OP_WEEK && r_op != OP_MONTH)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: if (s_sts.done) n_state = S_DONE;
            S_DONE: if (o_rsp.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op    <= t_op'(i_req.operation);
                r_day   <= (i_req.day_in == 5'd0) ? DAY_FIRST : i_req.day_in;
                r_month <= (i_req.month_in == 4'd0) ? MONTH_JAN :
                           (i_req.month_in > MONTH_DEC) ? MONTH_DEC : i_req.month_in;
                r_year  <= i_req.year_in;
                r_uf    <= 1'b0;
                if (t_op'(i_req.operation) == OP_WEEK) begin
                    r_rem <= (REM_BITS'(i_req.step_count) << 3) -
                             REM_BITS'(i_req.step_count);
                end else begin
                    r_rem <= REM_BITS'(i_req.step_count);
                end
            end
            S_PREP: r_prod <= PW'(mul_a) * PW'(mul_b);
            S_FIX: begin
                if (year_op) begin
                    if (r_prod > PW'(r_year)) begin
                        r_year <= '0;
                        r_uf   <= 1'b1;
                    end else begin
                        r_year <= r_year - r_prod[YEAR_BITS-1:0];
                    end
                end
                r_r25 <= fix_r[4:0];
            end
            S_WALK: begin
                r_day   <= s_day;
                r_month <= s_month;
                r_year  <= s_year;
                r_r25   <= s_r25;
                r_rem   <= s_rem;
                r_uf    <= s_sts.uf;
            end
            default: ;
        endcase
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = (r_state == S_DONE);
    assign o_rsp.day_out        = r_day;
    assign o_rsp.month_out      = r_month;
    assign o_rsp.year_out       = r_year;
    assign o_rsp.year_underflow = r_uf;

endmodule

[sv/cdd_step.sv]
// Shared step unit: moves a date back by one month, or by up to one month of days.
// Depends on cdd_pkg.
module cdd_step
    import cdd_pkg::*;
#(
    parameter int YEAR_BITS = 14,
    parameter int REM_BITS  = 13
) (
    input  logic                 i_month_mode,
    input  logic [4:0]           i_day,
    input  logic [3:0]           i_month,
    input  logic [YEAR_BITS-1:0] i_year,
    input  logic [4:0]           i_r25,
    input  logic [REM_BITS-1:0]  i_rem,
    output logic [4:0]           o_day,
    output logic [3:0]           o_month,
    output logic [YEAR_BITS-1:0] o_year,
    output logic [4:0]           o_r25,
    output logic [REM_BITS-1:0]  o_rem,
    output t_step_sts            o_sts
);

    logic [3:0]          prev_m;
    logic [4:0]          len_prev;
    logic [4:0]          r25_dec;
    logic [REM_BITS-1:0] day_ext;

    assign prev_m   = i_month - 4'd1;
    assign len_prev = month_len(prev_m, is_leap(i_year[3:0], i_r25));
    assign r25_dec  = (i_r25 == 5'd0) ? R25_TOP : i_r25 - 5'd1;
    assign day_ext  = REM_BITS'(i_day);

    always_comb begin
        o_day   = i_day;
        o_month = i_month;
        o_year  = i_year;
        o_r25   = i_r25;
        o_rem   = i_rem;
        o_sts   = '0;
        if (i_rem == '0) begin
            o_sts.done = 1'b1;
        end else if (i_month_mode) begin
            o_rem = i_rem - REM_BITS'(1);
            if (i_month > MONTH_JAN) begin
                o_month = prev_m;
                o_day   = (i_day > len_prev) ? len_prev : i_day;
            end else if (i_year != '0) begin
                o_year  = i_year - YEAR_BITS'(1);
                o_r25   = r25_dec;
                o_month = MONTH_DEC;
            end else begin
                o_day      = DAY_FIRST;
                o_month    = MONTH_JAN;
                o_rem      = i_rem;
                o_sts.done = 1'b1;
                o_sts.uf   = 1'b1;
            end
        end else begin
            if (i_rem < day_ext) begin
                // lands inside the current month
                o_day      = i_day - i_rem[4:0];
                o_rem      = '0;
                o_sts.done = 1'b1;
            end else if (i_month > MONTH_JAN) begin
                o_rem   = i_rem - day_ext;
                o_month = prev_m;
                o_day   = len_prev;
            end else if (i_year != '0) begin
                o_rem   = i_rem - day_ext;
                o_year  = i_year - YEAR_BITS'(1);
                o_r25   = r25_dec;
                o_month = MONTH_DEC;
                o_day   = DAY_DEC_LAST;
            end else begin
                o_day      = DAY_FIRST;
                o_sts.done = 1'b1;
                o_sts.uf   = 1'b1;
            end
        end
    end

endmodule

[sv/cdd_checker.sv]
// Port-level checker for calendar_date_decrement, bound to the top level.
// Depends on calendar_date_decrement_defines.svh.
`include "calendar_date_decrement_defines.svh"

module cdd_checker #(
    parameter int YEAR_BITS = 14
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_req_valid,
    input logic                 i_req_ready,
    input logic                 i_rsp_valid,
    input logic                 i_rsp_ready,
    input logic [4:0]           i_day,
    input logic [3:0]           i_month,
    input logic [YEAR_BITS-1:0] i_year,
    input logic                 i_uf
);

    // one request in flight: no new transfer while a result is pending
    `CDD_ASSERT_NEVER(a_busy_excl, i_clk, i_rst_n, i_req_ready && i_rsp_valid)

    `CDD_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_req_valid && i_req_ready,
                     !i_req_ready && !i_rsp_valid)

    `CDD_ASSERT_IMPL(a_uf_year_zero, i_clk, i_rst_n, i_rsp_valid && i_uf, i_year == '0)

    `CDD_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready,
                     i_rsp_valid && $stable(i_day) && $stable(i_month) &&
                     $stable(i_year) && $stable(i_uf))

endmodule

bind calendar_date_decrement cdd_checker #(
    .YEAR_BITS (YEAR_BITS)
) u_cdd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_day       (o_rsp.day_out),
    .i_month     (o_rsp.month_out),
    .i_year      (o_rsp.year_out),
    .i_uf        (o_rsp.year_underflow)
);
